// File: sv/cmil_pkg.sv
package cmil_pkg;

  localparam int MaxBands     = 8;
  localparam int MaxModes     = 8;
  localparam int MaxSamples   = 256;
  localparam int SidxW        = 8;
  localparam int SlotW        = 14;
  localparam int TimeW        = 48;
  localparam int ValW         = 32;
  localparam int MagW         = 33;
  localparam int ProdW        = 81;

  localparam logic [1:0] OP_WR_TIME   = 2'd0;
  localparam logic [1:0] OP_WR_SAMPLE = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_BAND = 2'd1;
  localparam logic [1:0] ST_BAD_MODE = 2'd2;
  localparam logic [1:0] ST_BAD_TIME = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch input item
    logic write_mem;   // perform load write
    logic rd_ends;     // latch t[0] and read t[n-1]
    logic chk_range;   // latch range check
    logic rd_mid;      // read time table at mid
    logic step;        // apply probe compare
    logic rd_pair;     // read t[lo] and first sample
    logic rd_pair2;    // read t[lo+1] and second sample
    logic setup;       // form num/den, magnitudes
    logic mul_lo;      // first partial product
    logic mul_hi;      // second partial product, start divide
    logic div_step;    // one quotient bit
    logic finish;      // apply quotients
    logic emit_zero;   // emit zero result with status
  } cmil_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] err;        // check status from fields and registers
    logic       range_bad;
    logic       search_done;
    logic       div_done;
  } cmil_sts_t;

endpackage

// File: sv/cmil_ctrl.sv
module cmil_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cmil_pkg::cmil_sts_t sts,
  output cmil_pkg::cmil_cmd_t cmd
);
  import cmil_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ENDS, S_RANGE, S_MID, S_STEP, S_PAIR, S_PAIR2,
    S_SETUP, S_MUL_LO, S_MUL_HI, S_DIV, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op != OP_QUERY) begin
          cmd.write_mem = 1'b1;
          cmd.emit_zero = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.err != ST_OK) begin
          cmd.emit_zero = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_ends = 1'b1;
          state_nxt = S_ENDS;
        end
      end
      S_ENDS: begin
        cmd.chk_range = 1'b1;
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        if (sts.range_bad) begin
          cmd.emit_zero = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.search_done) begin
          cmd.rd_pair = 1'b1;
          state_nxt = S_PAIR;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        cmd.step = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (sts.search_done) begin
          cmd.rd_pair = 1'b1;
          state_nxt = S_PAIR;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt = S_MID;
        end
      end
      S_PAIR: begin
        cmd.rd_pair2 = 1'b1;
        state_nxt = S_PAIR2;
      end
      S_PAIR2: begin
        cmd.setup = 1'b1;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.mul_lo = 1'b1;
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_hi = 1'b1;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.div_step = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: sv/cmil_dpath.sv
module cmil_dpath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmil_pkg::cmil_cmd_t      cmd,
  output cmil_pkg::cmil_sts_t      sts,
  input  logic [3:0]               cfg_num_bands,
  input  logic [8:0]               cfg_num_samples,
  input  logic [31:0]              cfg_mode_counts,
  input  logic [1:0]               in_mode,
  input  logic [2:0]               in_band,
  input  logic [2:0]               in_mode_index,
  input  logic [7:0]               in_sample_index,
  input  logic [47:0]              in_time_ms,
  input  logic signed [31:0]       in_value_re,
  input  logic signed [31:0]       in_value_im,
  output logic                     out_valid,
  output logic signed [31:0]       out_result_re,
  output logic signed [31:0]       out_result_im,
  output logic [1:0]               out_status,
  output logic [7:0]               out_interval_index
);
  import cmil_pkg::*;

  logic [TimeW-1:0] ttab [MaxSamples];
  logic [63:0]      smem [MaxBands*MaxModes*MaxSamples];

  logic [1:0]       op_r;
  logic [2:0]       band_r, midx_r;
  logic [SidxW-1:0] sidx_r;
  logic [TimeW-1:0] t_r;
  logic [31:0]      vre_r, vim_r;

  logic [8:0] n_sat;
  logic [3:0] nb_sat, nm_raw, nm_sat;
  logic [1:0] err;

  logic [TimeW-1:0] trd_r;     // time table read data
  logic [TimeW-1:0] t0_r;
  logic [63:0]      srd_r;     // sample read data
  logic [63:0]      e0_r;
  logic [8:0]       lo_r, hi_r;
  logic [8:0]       mid;
  logic             rng_bad_r;
  logic [TimeW-1:0] tfirst_r;

  logic [TimeW-1:0] num_r, den_r;
  logic             deg_r;
  logic [MagW-1:0]  mag_re_r, mag_im_r;
  logic             neg_re_r, neg_im_r;
  logic [56:0]      p0_re_r, p0_im_r;
  logic [ProdW-1:0] prod_re_r, prod_im_r;
  logic [TimeW:0]   rem_re_r, rem_im_r;
  logic [ProdW-1:0] q_re_r, q_im_r;
  logic [6:0]       cnt_r;

  logic [SlotW-1:0] slot_base;

  // saturate registers and check band and mode
  always_comb begin
    if (cfg_num_samples < 9'd2)                    n_sat = 9'd2;
    else if (cfg_num_samples > 9'(MaxSamples))     n_sat = 9'(MaxSamples);
    else                                           n_sat = cfg_num_samples;
    nb_sat = (cfg_num_bands > 4'(MaxBands)) ? 4'(MaxBands) : cfg_num_bands;
    nm_raw = cfg_mode_counts[{band_r, 2'b00} +: 4];
    nm_sat = (nm_raw > 4'(MaxModes)) ? 4'(MaxModes) : nm_raw;
    if ({1'b0, band_r} >= nb_sat)      err = ST_BAD_BAND;
    else if ({1'b0, midx_r} >= nm_sat) err = ST_BAD_MODE;
    else                               err = ST_OK;
  end

  assign mid       = (lo_r + hi_r) >> 1;
  assign slot_base = {band_r, midx_r, 8'd0};

  assign sts.op          = op_r;
  assign sts.err         = err;
  assign sts.range_bad   = rng_bad_r;
  assign sts.search_done = (hi_r <= lo_r + 9'd1);
  assign sts.div_done    = (cnt_r == 7'd0);

  // capture item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_mode;
      band_r <= in_band;
      midx_r <= in_mode_index;
      sidx_r <= in_sample_index;
      t_r    <= in_time_ms;
      vre_r  <= in_value_re;
      vim_r  <= in_value_im;
    end
  end

  // time table port
  always_ff @(posedge clk) begin
    if (cmd.write_mem && op_r == OP_WR_TIME) begin
      ttab[sidx_r] <= t_r;
    end
    if (cmd.rd_ends) begin
      trd_r <= ttab[8'(n_sat - 9'd1)];
    end else if (cmd.rd_mid) begin
      trd_r <= ttab[mid[7:0]];
    end else if (cmd.rd_pair) begin
      trd_r <= ttab[lo_r[7:0]];
    end else if (cmd.rd_pair2) begin
      trd_r <= ttab[8'(lo_r + 9'd1)];
    end else if (cmd.capture) begin
      trd_r <= ttab[0];
    end
  end

  // sample memory port
  always_ff @(posedge clk) begin
    if (cmd.write_mem && op_r == OP_WR_SAMPLE) begin
      smem[{band_r, midx_r, sidx_r}] <= {vim_r, vre_r};
    end
    if (cmd.rd_pair) begin
      srd_r <= smem[slot_base | SlotW'(lo_r[7:0])];
    end else if (cmd.rd_pair2) begin
      srd_r <= smem[slot_base | SlotW'(8'(lo_r + 9'd1))];
    end
  end

  // range check, search and latch of the first pair
  always_ff @(posedge clk) begin
    if (cmd.rd_ends) begin
      tfirst_r <= trd_r;
      lo_r     <= 9'd0;
      hi_r     <= n_sat - 9'd1;
    end
    if (cmd.chk_range) begin
      rng_bad_r <= (t_r < tfirst_r) || (t_r > trd_r);
    end
    if (cmd.step) begin
      if (trd_r > t_r) hi_r <= mid;
      else             lo_r <= mid;
    end
    if (cmd.rd_pair2) begin
      t0_r <= trd_r;
      e0_r <= srd_r;
    end
  end

  // interpolation setup, products and serial divide
  always_ff @(posedge clk) begin
    logic signed [MagW-1:0] dre, dim;
    dre = MagW'($signed(srd_r[31:0])) - MagW'($signed(e0_r[31:0]));
    dim = MagW'($signed(srd_r[63:32])) - MagW'($signed(e0_r[63:32]));
    if (cmd.setup) begin
      deg_r <= !(trd_r > t0_r);
      den_r <= trd_r - t0_r;
      if (t_r <= t0_r)      num_r <= '0;
      else if (t_r >= trd_r) num_r <= trd_r - t0_r;
      else                   num_r <= t_r - t0_r;
      neg_re_r <= dre[MagW-1];
      neg_im_r <= dim[MagW-1];
      mag_re_r <= dre[MagW-1] ? MagW'(-dre) : dre;
      mag_im_r <= dim[MagW-1] ? MagW'(-dim) : dim;
    end
    if (cmd.mul_lo) begin
      p0_re_r <= {24'd0, mag_re_r} * {33'd0, num_r[23:0]};
      p0_im_r <= {24'd0, mag_im_r} * {33'd0, num_r[23:0]};
    end
    if (cmd.mul_hi) begin
      prod_re_r <= {24'd0, p0_re_r} + {{24'd0, mag_re_r} * {33'd0, num_r[47:24]}, 24'd0};
      prod_im_r <= {24'd0, p0_im_r} + {{24'd0, mag_im_r} * {33'd0, num_r[47:24]}, 24'd0};
      rem_re_r  <= '0;
      rem_im_r  <= '0;
      q_re_r    <= '0;
      q_im_r    <= '0;
      cnt_r     <= 7'(ProdW);
    end else if (cmd.div_step) begin
      logic [TimeW:0] rr, ri;
      rr = {rem_re_r[TimeW-1:0], prod_re_r[ProdW-1]};
      ri = {rem_im_r[TimeW-1:0], prod_im_r[ProdW-1]};
      prod_re_r <= prod_re_r << 1;
      prod_im_r <= prod_im_r << 1;
      if (rr >= {1'b0, den_r}) begin
        rem_re_r <= rr - {1'b0, den_r};
        q_re_r   <= {q_re_r[ProdW-2:0], 1'b1};
      end else begin
        rem_re_r <= rr;
        q_re_r   <= {q_re_r[ProdW-2:0], 1'b0};
      end
      if (ri >= {1'b0, den_r}) begin
        rem_im_r <= ri - {1'b0, den_r};
        q_im_r   <= {q_im_r[ProdW-2:0], 1'b1};
      end else begin
        rem_im_r <= ri;
        q_im_r   <= {q_im_r[ProdW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 7'd1;
    end
  end

  // drive result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit_zero || cmd.finish;
    end
    if (cmd.emit_zero) begin
      out_result_re      <= '0;
      out_result_im      <= '0;
      out_interval_index <= '0;
      if (op_r != OP_QUERY)  out_status <= ST_OK;
      else if (err != ST_OK) out_status <= err;
      else                   out_status <= ST_BAD_TIME;
    end else if (cmd.finish) begin
      out_status         <= ST_OK;
      out_interval_index <= lo_r[7:0];
      if (deg_r) begin
        out_result_re <= e0_r[31:0];
        out_result_im <= e0_r[63:32];
      end else begin
        out_result_re <= neg_re_r ? e0_r[31:0] - q_re_r[31:0] : e0_r[31:0] + q_re_r[31:0];
        out_result_im <= neg_im_r ? e0_r[63:32] - q_im_r[31:0]
                                  : e0_r[63:32] + q_im_r[31:0];
      end
    end
  end

endmodule

// File: sv/complex_mode_interpolating_lookup_unit.sv
// Interpolating complex table lookup. Pulse start while busy is low; one
// result beat follows on out_valid for a single cycle and cannot be stalled.
// Loads and band or mode rejections are answered from the decode state; a
// time out of range is answered after the range check. A valid query runs
// up to 8 time-table probes on the single read port, sample reads, two
// partial-product steps, and a restoring divide that works one quotient bit
// per cycle. A new start is taken in the result cycle.
module complex_mode_interpolating_lookup_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         in_mode,
  input  logic [2:0]         in_band,
  input  logic [2:0]         in_mode_index,
  input  logic [7:0]         in_sample_index,
  input  logic [47:0]        in_time_ms,
  input  logic signed [31:0] in_value_re,
  input  logic signed [31:0] in_value_im,
  output logic               out_valid,
  output logic signed [31:0] out_result_re,
  output logic signed [31:0] out_result_im,
  output logic [1:0]         out_status,
  output logic [7:0]         out_interval_index
);
  import cmil_pkg::*;

  localparam logic [1:0] REG_NUM_BANDS   = 2'd0;
  localparam logic [1:0] REG_NUM_SAMPLES = 2'd1;
  localparam logic [1:0] REG_MODE_COUNTS = 2'd2;

  logic [3:0]  num_bands_r;
  logic [8:0]  num_samples_r;
  logic [31:0] mode_counts_r;
  cmil_cmd_t   cmd;
  cmil_sts_t   sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bands_r   <= 4'd8;
      num_samples_r <= 9'd256;
      mode_counts_r <= 32'h8888_8888;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_BANDS:   num_bands_r   <= cfg_data[3:0];
        REG_NUM_SAMPLES: num_samples_r <= cfg_data[8:0];
        REG_MODE_COUNTS: mode_counts_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cmil_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  cmil_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_num_bands(num_bands_r), .cfg_num_samples(num_samples_r),
    .cfg_mode_counts(mode_counts_r),
    .in_mode(in_mode), .in_band(in_band), .in_mode_index(in_mode_index),
    .in_sample_index(in_sample_index), .in_time_ms(in_time_ms),
    .in_value_re(in_value_re), .in_value_im(in_value_im),
    .out_valid(out_valid), .out_result_re(out_result_re),
    .out_result_im(out_result_im), .out_status(out_status),
    .out_interval_index(out_interval_index)
  );

endmodule
